// ----- rtl/per_source_packet_throttle_top_macros.svh -----
// Assertion macros for the per-source packet throttle.
// Used by per_source_packet_throttle_top, which checks its own logic; no other dependencies.
`ifndef PER_SOURCE_PACKET_THROTTLE_TOP_MACROS_SVH
`define PER_SOURCE_PACKET_THROTTLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define PST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("throttle assertion failed");
// Checked on every edge, reset included.
`define PST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("throttle assertion failed");
`else
`define PST_ASSERT(lbl, prop)
`define PST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/pst_pkg.sv -----
// Shared types and constants of the per-source packet throttle.
// No dependencies; used by pst_cell and per_source_packet_throttle_top.
package pst_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int ADDR_W    = 64;
    localparam int COUNT_W   = 8;
    localparam int WINDOW_W  = 12;
    localparam int SECONDS_W = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 12'd60;
    localparam logic [COUNT_W-1:0]  LIMIT_RESET  = 8'd255;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_KNOWN     = 2'd0;
    localparam logic [1:0] ST_NEW       = 2'd1;
    localparam logic [1:0] ST_THROTTLED = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic                accept;   // packet taken this cycle, run the compare
        logic                clear;    // window expired, drop all entries
        logic                commit;   // resolve step, apply the update
        logic                alloc;    // no hit and room left, first free cell takes key
        logic [ADDR_W-1:0]   cmp_hi;
        logic [ADDR_W-1:0]   cmp_lo;
        logic [ADDR_W-1:0]   wr_hi;
        logic [ADDR_W-1:0]   wr_lo;
        logic [COUNT_W-1:0]  limit;
    } t_cell_ctl;

    // Status returned by each cell.
    typedef struct packed {
        logic valid;
        logic hit;
        logic at_limit;
    } t_cell_stat;

endpackage

// ----- rtl/per_source_packet_throttle_top.sv -----
// Top level of the per-source packet throttle: handshakes, window timer and
// result logic around a chain of pst_cell entries. Depends on pst_pkg.
//
// Channel   Direction  Handshake                 Payload
// s_axis    in         tvalid / tready           tdata: address_high, address_low; tuser: kind
// m_axis    out        tvalid / tready           tdata: status, allowed
// cfg       in         write enable, no wait     index 0 window_seconds, 1 throttle_limit
//
// A tick is accepted and gives no result. A packet has an accept step and a resolve
// step: in the accept step, every cell compares its stored address with the incoming
// one and latches a hit bit; in the resolve step, which may stall, the hit, limit and
// full flags are combined across the cells and the result goes to the output register.
// The next item is accepted while a result waits to be taken; the resolve step
// stalls only if the previous result is still held. Reset is synchronous; in the
// table only the valid and hit bits are cleared, so there is no clearing pass over
// the entries.
`include "per_source_packet_throttle_top_macros.svh"
module per_source_packet_throttle_top
    import pst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [127:0]          i_s_axis_tdata,  // [63:0] address_high, [127:64] address_low
    input  logic                  i_s_axis_tuser,  // [0] kind: 0 packet, 1 tick
    // Result stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,  // [1:0] status, [2] allowed, [7:3] zero
    // Configuration writes.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic                 r_busy;
    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic                 r_out_allowed;
    logic [SECONDS_W-1:0] r_seconds;
    logic [WINDOW_W-1:0]  r_window;
    logic [COUNT_W-1:0]   r_limit;
    logic [ADDR_W-1:0]    r_key_hi;
    logic [ADDR_W-1:0]    r_key_lo;

    logic                 w_accept;
    logic                 w_packet;
    logic                 w_tick;
    logic                 w_clear;
    logic                 w_fire;
    logic                 w_any_hit;
    logic                 w_any_limit;
    logic                 w_full;
    logic [1:0]           n_status;
    t_cell_ctl            w_ctl;
    t_cell_stat           w_stat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_limit_hit;
    logic [TABLE_DEPTH-1:0] w_valid_inc;

    // The input side is blocked only during the resolve step of a packet.
    assign o_s_axis_tready = !r_busy;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_packet = w_accept && !i_s_axis_tuser;
    assign w_tick   = w_accept && i_s_axis_tuser;

    // The window expires strictly after window_seconds ticks have passed.
    assign w_clear = (r_seconds > r_window);

    // The resolve step runs when the output register is free or being emptied.
    assign w_fire = r_busy && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        w_ctl.accept = w_packet;
        w_ctl.clear  = w_clear;
        w_ctl.commit = w_fire;
        w_ctl.alloc  = !w_any_hit && !w_full;
        w_ctl.cmp_hi = i_s_axis_tdata[ADDR_W-1:0];
        w_ctl.cmp_lo = i_s_axis_tdata[2*ADDR_W-1:ADDR_W];
        w_ctl.wr_hi  = r_key_hi;
        w_ctl.wr_lo  = r_key_lo;
        w_ctl.limit  = r_limit;
    end

    // Chain of entries; each cell sees whether its lower neighbor is in use.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic w_prev_valid;
        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
        end else begin : g_rest
            assign w_prev_valid = w_stat[g-1].valid;
        end

        pst_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid (w_prev_valid),
            .o_stat       (w_stat[g])
        );

        assign w_valid[g]     = w_stat[g].valid;
        assign w_hit[g]       = w_stat[g].hit;
        assign w_limit_hit[g] = w_stat[g].at_limit;
    end

    assign w_any_hit   = |w_hit;
    assign w_any_limit = |w_limit_hit;
    // The table is full once the last cell of the chain holds an entry.
    assign w_full      = w_valid[TABLE_DEPTH-1];

    always_comb begin
        if (w_any_hit) begin
            n_status = w_any_limit ? ST_THROTTLED : ST_KNOWN;
        end else if (w_full) begin
            n_status = ST_FULL;
        end else begin
            n_status = ST_NEW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_seconds   <= '0;
            r_window    <= WINDOW_RESET;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (w_packet) begin
                r_busy <= 1'b1;
            end else if (w_fire) begin
                r_busy <= 1'b0;
            end

            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Saturating seconds counter, restarted when a packet finds the
            // window expired.
            if (w_tick) begin
                if (r_seconds != '1) begin
                    r_seconds <= r_seconds + SECONDS_W'(1);
                end
            end else if (w_packet && w_clear) begin
                r_seconds <= '0;
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW: r_window <= i_cfg_data[WINDOW_W-1:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_packet) begin
            r_key_hi <= i_s_axis_tdata[ADDR_W-1:0];
            r_key_lo <= i_s_axis_tdata[2*ADDR_W-1:ADDR_W];
        end
        if (w_fire) begin
            r_out_status  <= n_status;
            r_out_allowed <= (n_status == ST_KNOWN) || (n_status == ST_NEW);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_allowed, r_out_status};

    // Valid bits must stay a run of ones from the bottom of the chain.
    assign w_valid_inc = w_valid + TABLE_DEPTH'(1);

    `PST_ASSERT(a_valid_packed, (w_valid_inc & w_valid) == '0)
    `PST_ASSERT(a_single_hit, $onehot0(w_hit))
    `PST_ASSERT(a_hold_when_stalled, r_busy && r_out_valid && !i_m_axis_tready |=> r_busy)
    `PST_ASSERT(a_result_from_resolve, $rose(o_m_axis_tvalid) |-> $past(r_busy))
    `PST_ASSERT(a_limit_only_on_hit, (w_limit_hit & ~w_hit) == '0)

endmodule

// ----- rtl/pst_cell.sv -----
// One table entry of the packet throttle: address, packet count and valid bit.
// Depends on pst_pkg; chained by per_source_packet_throttle_top.
module pst_cell
    import pst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  logic       i_prev_valid,
    output t_cell_stat o_stat
);

    logic                r_valid;
    logic                r_hit;
    logic [ADDR_W-1:0]   r_addr_hi;
    logic [ADDR_W-1:0]   r_addr_lo;
    logic [COUNT_W-1:0]  r_count;

    logic w_take;
    logic w_match;
    logic w_at_limit;

    // Entries fill from the low end, so the first free cell is the one whose
    // neighbor below is valid while it is not.
    assign w_take     = i_ctl.commit && i_ctl.alloc && !r_valid && i_prev_valid;
    assign w_match    = (r_addr_hi == i_ctl.cmp_hi) && (r_addr_lo == i_ctl.cmp_lo);
    assign w_at_limit = (r_count >= i_ctl.limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_ctl.accept) begin
            r_valid <= r_valid && !i_ctl.clear;
            r_hit   <= r_valid && !i_ctl.clear && w_match;
        end else if (i_ctl.commit) begin
            r_hit <= 1'b0;
            if (w_take) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_addr_hi <= i_ctl.wr_hi;
            r_addr_lo <= i_ctl.wr_lo;
            r_count   <= COUNT_W'(1);
        end else if (i_ctl.commit && r_hit && !w_at_limit) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    assign o_stat.valid    = r_valid;
    assign o_stat.hit      = r_hit;
    assign o_stat.at_limit = r_hit && w_at_limit;

endmodule
